// File: rtl/lzwe_pkg.sv
// lzwe_pkg: shared constants, types and state codes of the lzw byte stream encoder
// no dependencies
package lzwe_pkg;

	localparam int HASH_SLOTS = 5003;
	localparam int IDX_W = $clog2(HASH_SLOTS);

	localparam logic [11:0] CLEAR_CODE = 12'd256;
	localparam logic [11:0] END_CODE = 12'd257;
	localparam logic [11:0] FIRST_FREE = 12'd258;
	localparam logic [11:0] CODE_CEILING = 12'd4094;
	localparam logic [3:0] START_WIDTH = 4'd9;
	localparam logic [12:0] START_LIMIT = 13'd512;

	typedef struct packed {
		logic used;
		logic [19:0] key;
		logic [11:0] code;
	} slot_t;

	typedef struct packed {
		logic valid;
		logic [11:0] code;
		logic [3:0] width;
		logic last;
		logic fin;
	} push_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_PROBE,
		ST_MISS,
		ST_CLEAR,
		ST_END_PFX,
		ST_END_CODE
	} state_t;

endpackage

// File: rtl/lzwe_hash_ram.sv
// lzwe_hash_ram: hash slot memory, one write port and one registered read port
// depends on lzwe_pkg
module lzwe_hash_ram (
	input  logic clk,
	input  logic rd_en,
	input  logic [lzwe_pkg::IDX_W-1:0] rd_addr,
	output lzwe_pkg::slot_t rd_data,
	input  logic wr_en,
	input  logic [lzwe_pkg::IDX_W-1:0] wr_addr,
	input  lzwe_pkg::slot_t wr_data
);
	lzwe_pkg::slot_t mem [lzwe_pkg::HASH_SLOTS];
	lzwe_pkg::slot_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

// File: rtl/lzwe_packer.sv
// lzwe_packer: msb-first bit packer with byte output register
// depends on lzwe_pkg
module lzwe_packer (
	input  logic clk,
	input  logic arst_n,
	input  lzwe_pkg::push_t push,
	output logic idle,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] out_byte,
	output logic run_last,
	output logic stream_end
);
	logic [20:0] acc_q;
	logic [4:0] bits_q;
	logic drain_q, pad_q, last_q, fin_q;
	logic out_valid_q, run_last_q, stream_end_q;
	logic [7:0] out_byte_q;
	logic load_ok;
	logic [4:0] bits_left;
	logic [20:0] acc_sh;
	logic [20:0] acc_pad;

	assign idle = !drain_q && !pad_q;
	assign load_ok = !out_valid_q || !out_stall;
	assign bits_left = bits_q - 5'd8;
	assign acc_sh = acc_q >> bits_left;
	assign acc_pad = acc_q << (5'd8 - bits_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 21'(lzwe_pkg::CLEAR_CODE);
			bits_q <= 5'(lzwe_pkg::START_WIDTH);
			drain_q <= 1'b0;
			pad_q <= 1'b0;
			last_q <= 1'b0;
			fin_q <= 1'b0;
			out_valid_q <= 1'b0;
			run_last_q <= 1'b0;
			stream_end_q <= 1'b0;
			out_byte_q <= 8'd0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (push.valid) begin
				acc_q <= (acc_q << push.width) | 21'(push.code);
				bits_q <= bits_q + 5'(push.width);
				drain_q <= 1'b1;
				last_q <= push.last;
				fin_q <= push.fin;
			end else if (drain_q && load_ok) begin
				out_valid_q <= 1'b1;
				out_byte_q <= acc_sh[7:0];
				run_last_q <= last_q && (bits_left < 5'd8) && !(fin_q && bits_left != 5'd0);
				stream_end_q <= fin_q && bits_left == 5'd0;
				bits_q <= bits_left;
				if (bits_left < 5'd8) begin
					drain_q <= 1'b0;
					if (fin_q && bits_left != 5'd0) begin
						pad_q <= 1'b1;
					end else if (fin_q) begin
						// stream done, reload the opening clear code
						acc_q <= 21'(lzwe_pkg::CLEAR_CODE);
						bits_q <= 5'(lzwe_pkg::START_WIDTH);
					end
				end
			end else if (pad_q && load_ok) begin
				out_valid_q <= 1'b1;
				out_byte_q <= acc_pad[7:0];
				run_last_q <= 1'b1;
				stream_end_q <= 1'b1;
				pad_q <= 1'b0;
				acc_q <= 21'(lzwe_pkg::CLEAR_CODE);
				bits_q <= 5'(lzwe_pkg::START_WIDTH);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign run_last = run_last_q;
	assign stream_end = stream_end_q;
endmodule

// File: rtl/lzw_byte_stream_encoder.sv
// lzw_byte_stream_encoder: top level, control sequencer around the hash memory
// depends on lzwe_pkg, lzwe_hash_ram, lzwe_packer
//
// usage
// - input channel: one raw byte per transfer (data_byte), end_of_data marks
//   the last byte of a stream and flushes prefix, end code and pad bits
// - output channel: packed msb-first code bytes; run_last marks the last byte
//   caused by an input transfer, stream_end the final byte of a stream
// - pacing: a byte that hits on the first probe passes the probe state back to
//   idle, one that misses passes the miss state as well; each extra hash probe
//   adds a probe read, every code push (miss, clear, flush) first waits for the
//   bit packer to drain its previous bytes, and no new byte is taken before idle
// - the single-port-read hash memory sets the pace: one probe per cycle
// - a table clear (code space full, or end of stream) sweeps all 5003 hash
//   slots, one per cycle, during which in_stall is high
// - after reset the same sweep runs before the first transfer
// - output stalls hold the output register; the packer stops draining and the
//   input side stalls at the next code push
module lzw_byte_stream_encoder (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] data_byte,
	input  logic end_of_data,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] out_byte,
	output logic run_last,
	output logic stream_end
);
	localparam int IW = lzwe_pkg::IDX_W;

	lzwe_pkg::state_t state_q, state_d;

	logic [11:0] prefix_q;
	logic [11:0] next_code_q;
	logic [3:0] width_q;
	logic [12:0] limit_q;
	logic first_q;
	logic [7:0] byte_q;
	logic end_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] disp_q;
	logic [IW-1:0] sweep_q;

	// memory and packer hookup
	logic rd_en, wr_en;
	logic [IW-1:0] rd_addr, wr_addr;
	lzwe_pkg::slot_t rd_data, wr_data;
	lzwe_pkg::push_t push;
	logic pk_idle;

	logic accept;
	logic [IW-1:0] first_idx;
	logic [IW-1:0] first_disp;
	logic [IW:0] step_sum;
	logic [IW-1:0] step_idx;
	logic key_hit;

	assign accept = in_valid && !in_stall;
	assign in_stall = state_q != lzwe_pkg::ST_IDLE;

	// first probe: the xor of the shifted byte and the prefix is below the slot count
	assign first_idx = IW'({data_byte, 4'b0000} ^ prefix_q);
	assign first_disp = (first_idx == '0) ? IW'(1) : IW'(lzwe_pkg::HASH_SLOTS) - first_idx;

	// secondary probe: step down by the displacement, wrapping modulo the slot count
	assign step_sum = (idx_q >= disp_q) ? ({1'b0, idx_q} - {1'b0, disp_q})
		: ({1'b0, idx_q} + (IW+1)'(lzwe_pkg::HASH_SLOTS) - {1'b0, disp_q});
	assign step_idx = step_sum[IW-1:0];

	assign key_hit = rd_data.key == {byte_q, prefix_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzwe_pkg::ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en = 1'b0;
		rd_addr = first_idx;
		wr_en = 1'b0;
		wr_addr = idx_q;
		wr_data = '0;
		push = '0;
		case (state_q)
			lzwe_pkg::ST_SWEEP: begin
				wr_en = 1'b1;
				wr_addr = sweep_q;
				if (sweep_q == IW'(lzwe_pkg::HASH_SLOTS - 1)) begin
					state_d = end_q ? lzwe_pkg::ST_END_PFX : lzwe_pkg::ST_IDLE;
				end
			end
			lzwe_pkg::ST_IDLE: begin
				if (accept) begin
					if (first_q) begin
						state_d = end_of_data ? lzwe_pkg::ST_END_PFX : lzwe_pkg::ST_IDLE;
					end else begin
						rd_en = 1'b1;
						state_d = lzwe_pkg::ST_PROBE;
					end
				end
			end
			lzwe_pkg::ST_PROBE: begin
				if (!rd_data.used) begin
					state_d = lzwe_pkg::ST_MISS;
				end else if (key_hit) begin
					state_d = end_q ? lzwe_pkg::ST_END_PFX : lzwe_pkg::ST_IDLE;
				end else begin
					rd_en = 1'b1;
					rd_addr = step_idx;
				end
			end
			lzwe_pkg::ST_MISS: begin
				if (pk_idle) begin
					push.valid = 1'b1;
					push.code = prefix_q;
					push.width = width_q;
					// a clear code follows when the code space is full
					push.last = !end_q && (next_code_q < lzwe_pkg::CODE_CEILING);
					if (next_code_q < lzwe_pkg::CODE_CEILING) begin
						wr_en = 1'b1;
						wr_data.used = 1'b1;
						wr_data.key = {byte_q, prefix_q};
						wr_data.code = next_code_q;
						state_d = end_q ? lzwe_pkg::ST_END_PFX : lzwe_pkg::ST_IDLE;
					end else begin
						state_d = lzwe_pkg::ST_CLEAR;
					end
				end
			end
			lzwe_pkg::ST_CLEAR: begin
				if (pk_idle) begin
					push.valid = 1'b1;
					push.code = lzwe_pkg::CLEAR_CODE;
					push.width = width_q;
					push.last = !end_q;
					state_d = lzwe_pkg::ST_SWEEP;
				end
			end
			lzwe_pkg::ST_END_PFX: begin
				if (pk_idle) begin
					push.valid = 1'b1;
					push.code = prefix_q;
					push.width = width_q;
					state_d = lzwe_pkg::ST_END_CODE;
				end
			end
			lzwe_pkg::ST_END_CODE: begin
				if (pk_idle) begin
					push.valid = 1'b1;
					push.code = lzwe_pkg::END_CODE;
					push.width = width_q;
					push.last = 1'b1;
					push.fin = 1'b1;
					state_d = lzwe_pkg::ST_SWEEP;
				end
			end
			default: begin
				state_d = lzwe_pkg::ST_SWEEP;
			end
		endcase
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= '0;
			next_code_q <= lzwe_pkg::FIRST_FREE;
			width_q <= lzwe_pkg::START_WIDTH;
			limit_q <= lzwe_pkg::START_LIMIT;
			first_q <= 1'b1;
			end_q <= 1'b0;
			sweep_q <= '0;
			byte_q <= '0;
			idx_q <= '0;
			disp_q <= '0;
		end else begin
			case (state_q)
				lzwe_pkg::ST_SWEEP: begin
					sweep_q <= (sweep_q == IW'(lzwe_pkg::HASH_SLOTS - 1)) ? '0 : sweep_q + 1'b1;
				end
				lzwe_pkg::ST_IDLE: begin
					if (accept) begin
						byte_q <= data_byte;
						end_q <= end_of_data;
						idx_q <= first_idx;
						disp_q <= first_disp;
						if (first_q) begin
							prefix_q <= 12'(data_byte);
							first_q <= 1'b0;
						end
					end
				end
				lzwe_pkg::ST_PROBE: begin
					if (rd_data.used && key_hit) begin
						prefix_q <= rd_data.code;
					end else if (rd_data.used) begin
						idx_q <= step_idx;
					end
				end
				lzwe_pkg::ST_MISS: begin
					if (pk_idle) begin
						prefix_q <= 12'(byte_q);
						if (next_code_q < lzwe_pkg::CODE_CEILING) begin
							// early width change, just before the code is handed out
							if (13'(next_code_q) >= limit_q - 13'd1) begin
								width_q <= width_q + 4'd1;
								limit_q <= limit_q << 1;
							end
							next_code_q <= next_code_q + 12'd1;
						end
					end
				end
				lzwe_pkg::ST_CLEAR: begin
					if (pk_idle) begin
						next_code_q <= lzwe_pkg::FIRST_FREE;
						width_q <= lzwe_pkg::START_WIDTH;
						limit_q <= lzwe_pkg::START_LIMIT;
					end
				end
				lzwe_pkg::ST_END_CODE: begin
					if (pk_idle) begin
						// back to the start of a new stream
						prefix_q <= '0;
						next_code_q <= lzwe_pkg::FIRST_FREE;
						width_q <= lzwe_pkg::START_WIDTH;
						limit_q <= lzwe_pkg::START_LIMIT;
						first_q <= 1'b1;
						end_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	lzwe_hash_ram u_ram (
		.clk(clk),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	lzwe_packer u_packer (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.idle(pk_idle),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.run_last(run_last),
		.stream_end(stream_end)
	);

	// a code push never lands on a packer that is still draining
	a_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> pk_idle) else $error("code push while packer busy");

	// the final byte of a stream also closes its input transfer
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_end |-> run_last) else $error("stream end without run last");

	// code width stays in the 9 to 12 bit range
	a_width: assert property (@(posedge clk) disable iff (!arst_n)
		width_q >= lzwe_pkg::START_WIDTH && width_q <= 4'd12) else $error("code width out of range");

	// dictionary codes never pass the ceiling
	a_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		next_code_q <= lzwe_pkg::CODE_CEILING) else $error("next code past ceiling");
endmodule
